// ===== sv/qfbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfbp_pkg
// Types, codes and the frame grammar table of the QUIC frame boundary parser.
// ----------------------------------------------------------------------------
package qfbp_pkg;

   localparam int QFBP_COUNT_WIDTH = 16;
   localparam int QFBP_Q_DEPTH     = 4;
   localparam int QFBP_Q_AW        = $clog2(QFBP_Q_DEPTH);

   localparam logic [7:0] QFBP_TYPE_PADDING = 8'h00;
   localparam logic [7:0] QFBP_LAST_TYPE    = 8'h1d;

   // bytes still skipped after the first byte of a fixed field
   localparam logic [61:0] QFBP_FIX2_SKIP  = 62'd1;
   localparam logic [61:0] QFBP_FIX8_SKIP  = 62'd7;
   localparam logic [61:0] QFBP_FIX16_SKIP = 62'd15;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_TRUNC   = 2'd1,
      STATUS_UNKNOWN = 2'd2,
      STATUS_PAD_END = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      OP_END,
      OP_VAR,
      OP_VCNT,
      OP_PAIRS,
      OP_VLEN,
      OP_U8LEN,
      OP_FIX2,
      OP_FIX8,
      OP_FIX16,
      OP_REST
   } op_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       payload_end;
   } req_type;

   typedef struct packed {
      logic [7:0]  frame_kind;
      logic [15:0] frame_bytes;
      logic [1:0]  status;
      logic        last_of_run;
   } rsp_type;

   // results written into the result queue in the same cycle
   typedef struct packed {
      logic [1:0] num;
      rsp_type    first;
      rsp_type    second;
   } push_type;

   typedef struct packed {
      logic       done;
      logic [3:0] step;
   } adv_type;

   // field grammar per frame type
   function automatic op_type grammar_op(input logic [7:0] kind, input logic [3:0] step);
      op_type op;
      op = OP_END;
      case (kind) inside
         8'h02: begin
            case (step) inside
               4'd0, 4'd1, 4'd3: op = OP_VAR;
               4'd2:             op = OP_VCNT;
               4'd4:             op = OP_PAIRS;
               default:          op = OP_END;
            endcase
         end
         8'h03: begin
            case (step) inside
               4'd0, 4'd1, 4'd3, 4'd5, 4'd6, 4'd7: op = OP_VAR;
               4'd2:                               op = OP_VCNT;
               4'd4:                               op = OP_PAIRS;
               default:                            op = OP_END;
            endcase
         end
         8'h04: begin
            case (step) inside
               4'd0, 4'd2: op = OP_VAR;
               4'd1:       op = OP_FIX2;
               default:    op = OP_END;
            endcase
         end
         8'h05: begin
            case (step) inside
               4'd0:    op = OP_VAR;
               4'd1:    op = OP_FIX2;
               default: op = OP_END;
            endcase
         end
         8'h06, 8'h0a, 8'h0b: begin
            case (step) inside
               4'd0:    op = OP_VAR;
               4'd1:    op = OP_VLEN;
               default: op = OP_END;
            endcase
         end
         8'h07: begin
            if (step == 4'd0) op = OP_VLEN;
         end
         8'h08, 8'h09: begin
            case (step) inside
               4'd0:    op = OP_VAR;
               4'd1:    op = OP_REST;
               default: op = OP_END;
            endcase
         end
         8'h0c, 8'h0d: begin
            case (step) inside
               4'd0, 4'd1: op = OP_VAR;
               4'd2:       op = OP_REST;
               default:    op = OP_END;
            endcase
         end
         8'h0e, 8'h0f: begin
            case (step) inside
               4'd0, 4'd1: op = OP_VAR;
               4'd2:       op = OP_VLEN;
               default:    op = OP_END;
            endcase
         end
         8'h10, 8'h12, 8'h13, 8'h14, 8'h16, 8'h17, 8'h19: begin
            if (step == 4'd0) op = OP_VAR;
         end
         8'h11, 8'h15: begin
            if (step == 4'd0 || step == 4'd1) op = OP_VAR;
         end
         8'h18: begin
            case (step) inside
               4'd0:    op = OP_VAR;
               4'd1:    op = OP_U8LEN;
               4'd2:    op = OP_FIX16;
               default: op = OP_END;
            endcase
         end
         8'h1a, 8'h1b: begin
            if (step == 4'd0) op = OP_FIX8;
         end
         8'h1c: begin
            case (step) inside
               4'd0:    op = OP_FIX2;
               4'd1:    op = OP_VAR;
               4'd2:    op = OP_VLEN;
               default: op = OP_END;
            endcase
         end
         8'h1d: begin
            case (step) inside
               4'd0:    op = OP_FIX2;
               4'd1:    op = OP_VLEN;
               default: op = OP_END;
            endcase
         end
         default: op = OP_END;
      endcase
      return op;
   endfunction

   // first field at or after step that consumes bytes; an empty ack range list is passed over
   function automatic adv_type advance_from(input logic [7:0] kind, input logic [3:0] step,
                                            input logic pairs_zero);
      adv_type r;
      op_type  op0;
      op_type  op1;
      op0    = grammar_op(kind, step);
      op1    = grammar_op(kind, step + 4'd1);
      r.done = 1'b0;
      r.step = step;
      if (op0 == OP_END) begin
         r.done = 1'b1;
      end else if (op0 == OP_PAIRS && pairs_zero) begin
         if (op1 == OP_END) r.done = 1'b1;
         else r.step = step + 4'd1;
      end
      return r;
   endfunction

endpackage

// ===== sv/qfbp_rsp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qfbp_rsp_queue
// Small result queue: takes up to two results a cycle, hands out one while rsp_stall is low.
// ----------------------------------------------------------------------------
module qfbp_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  qfbp_pkg::push_type push,
   output logic              has_room,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qfbp_pkg::rsp_type rsp_payload
);
   import qfbp_pkg::*;

   rsp_type              entry_ff [QFBP_Q_DEPTH];
   logic [QFBP_Q_AW-1:0] wr_ptr_ff;
   logic [QFBP_Q_AW-1:0] wr_ptr_in;
   logic [QFBP_Q_AW-1:0] rd_ptr_ff;
   logic [QFBP_Q_AW-1:0] rd_ptr_in;
   logic [QFBP_Q_AW:0]   fill_ff;
   logic [QFBP_Q_AW:0]   fill_in;
   logic                 pop;

   assign pop         = rsp_valid && !rsp_stall;
   assign rsp_valid   = (fill_ff != '0);
   assign rsp_payload = entry_ff[rd_ptr_ff];
   assign has_room    = (fill_ff <= (QFBP_Q_AW+1)'(QFBP_Q_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + QFBP_Q_AW'(push.num);
   assign rd_ptr_in = rd_ptr_ff + QFBP_Q_AW'(pop);
   assign fill_in   = fill_ff + (QFBP_Q_AW+1)'(push.num) - (QFBP_Q_AW+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) entry_ff[wr_ptr_ff] <= push.first;
      if (push.num == 2'd2) entry_ff[wr_ptr_ff + QFBP_Q_AW'(1)] <= push.second;
   end

endmodule

// ===== sv/quic_frame_boundary_parser_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quic_frame_boundary_parser_core
// Byte-serial QUIC frame boundary finder (draft-20 frame grammar).
// ----------------------------------------------------------------------------
// The block takes one decrypted payload byte per cycle on the req channel and
// reports one transaction on the rsp channel per frame end: frame type, byte
// count (saturating at 65535) and a status (ok, truncated, unknown type,
// padding to end). Every byte is parsed in the cycle it is accepted, so the
// sustained rate is one byte per clock. Most bytes give no result or one; a
// byte that closes a padding run and is itself a complete or failing frame
// gives two, which leave the four-entry result queue one at a time.
// req_stall rises only while that queue has fewer than two free entries, so
// with rsp_stall low the input never stalls. After an unknown frame type the
// rest of the payload is consumed silently; after payload_end the next byte
// is always read as a frame type.
// ----------------------------------------------------------------------------
module quic_frame_boundary_parser_core #(
   parameter int COUNT_WIDTH = qfbp_pkg::QFBP_COUNT_WIDTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  qfbp_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output qfbp_pkg::rsp_type rsp_payload
);
   import qfbp_pkg::*;

   typedef enum logic [1:0] {
      MODE_TYPE,
      MODE_FRAME,
      MODE_DISCARD
   } mode_type;

   // parser state
   mode_type               mode_ff,      mode_in;
   logic [3:0]             step_ff,      step_in;
   logic                   half_ff,      half_in;
   logic                   skip_ff,      skip_in;
   logic                   pad_ff,       pad_in;
   logic [7:0]             kind_ff,      kind_in;
   logic [61:0]            acc_ff,       acc_in;
   logic [2:0]             vleft_ff,     vleft_in;
   logic [61:0]            skip_cnt_ff,  skip_cnt_in;
   logic [61:0]            pairs_ff,     pairs_in;
   logic [COUNT_WIDTH-1:0] count_ff,     count_in;

   logic                   accept;
   logic                   has_room;
   logic [7:0]             b;
   logic                   fin;
   logic [COUNT_WIDTH-1:0] count_inc;
   op_type                 op_cur;
   push_type               push;

   // combinational scratch
   logic [61:0]            acc_n;
   logic [2:0]             vleft_n;
   logic [61:0]            pairs_dec;
   logic                   want_adv;
   logic                   fb_done;
   adv_type                adv_r;
   adv_type                adv_type0;
   rsp_type                tb_res;
   logic                   tb_emit;
   mode_type               tb_mode;
   logic                   tb_pad;
   rsp_type                r0;
   rsp_type                r1;
   logic [1:0]             n_res;
   logic                   rest_end;

   function automatic logic [15:0] sat16(input logic [COUNT_WIDTH-1:0] cnt);
      logic [31:0] wide;
      wide = 32'(cnt);
      return (wide > 32'h0000_ffff) ? 16'hffff : wide[15:0];
   endfunction

   function automatic rsp_type make_rsp(input logic [7:0] kind, input logic [15:0] bytes,
                                        input status_type st);
      rsp_type r;
      r.frame_kind  = kind;
      r.frame_bytes = bytes;
      r.status      = st;
      r.last_of_run = 1'b0;
      return r;
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = !has_room;
   assign b         = req_payload.data_byte;
   assign fin       = req_payload.payload_end;
   assign count_inc = (count_ff == '1) ? count_ff : count_ff + COUNT_WIDTH'(1);
   assign op_cur    = grammar_op(kind_ff, step_ff);

   // frame type byte handling, used in type mode and when a padding run closes
   always_comb begin
      adv_type0 = advance_from(b, 4'd0, 1'b1);
      tb_res    = make_rsp(b, 16'd1, STATUS_OK);
      tb_emit   = 1'b0;
      tb_mode   = MODE_TYPE;
      tb_pad    = 1'b0;
      if (b == QFBP_TYPE_PADDING) begin
         tb_res  = make_rsp(QFBP_TYPE_PADDING, 16'd1, STATUS_PAD_END);
         tb_emit = fin;
         tb_pad  = !fin;
      end else if (b > QFBP_LAST_TYPE) begin
         tb_res  = make_rsp(b, 16'd1, STATUS_UNKNOWN);
         tb_emit = 1'b1;
         tb_mode = fin ? MODE_TYPE : MODE_DISCARD;
      end else if (adv_type0.done) begin
         tb_emit = 1'b1;
      end else if (fin) begin
         tb_res  = make_rsp(b, 16'd1, STATUS_TRUNC);
         tb_emit = 1'b1;
      end else begin
         tb_mode = MODE_FRAME;
      end
   end

   // next state and results for the byte on the input
   always_comb begin
      mode_in     = mode_ff;
      step_in     = step_ff;
      half_in     = half_ff;
      skip_in     = skip_ff;
      pad_in      = pad_ff;
      kind_in     = kind_ff;
      acc_in      = acc_ff;
      vleft_in    = vleft_ff;
      skip_cnt_in = skip_cnt_ff;
      pairs_in    = pairs_ff;
      count_in    = count_ff;
      r0          = make_rsp(8'd0, 16'd0, STATUS_OK);
      r1          = make_rsp(8'd0, 16'd0, STATUS_OK);
      n_res       = 2'd0;
      want_adv    = 1'b0;
      fb_done     = 1'b0;
      rest_end    = 1'b0;
      pairs_dec   = (pairs_ff != '0) ? pairs_ff - 62'd1 : pairs_ff;

      // variable-length integer: 2-bit prefix gives the byte count
      if (vleft_ff == 3'd0) begin
         acc_n = 62'(b[5:0]);
         case (b[7:6])
            2'd0:    vleft_n = 3'd0;
            2'd1:    vleft_n = 3'd1;
            2'd2:    vleft_n = 3'd3;
            default: vleft_n = 3'd7;
         endcase
      end else begin
         acc_n   = {acc_ff[53:0], b};
         vleft_n = vleft_ff - 3'd1;
      end

      // byte inside a frame
      if (skip_ff) begin
         skip_cnt_in = skip_cnt_ff - 62'd1;
         if (skip_cnt_in == '0) begin
            skip_in  = 1'b0;
            want_adv = 1'b1;
         end
      end else begin
         case (op_cur) inside
            OP_VAR, OP_VCNT, OP_VLEN, OP_PAIRS: begin
               acc_in   = acc_n;
               vleft_in = vleft_n;
               if (vleft_n == 3'd0) begin
                  case (op_cur)
                     OP_VAR: want_adv = 1'b1;
                     OP_VCNT: begin
                        pairs_in = acc_n;
                        want_adv = 1'b1;
                     end
                     OP_VLEN: begin
                        if (acc_n == '0) begin
                           want_adv = 1'b1;
                        end else begin
                           skip_cnt_in = acc_n;
                           skip_in     = 1'b1;
                        end
                     end
                     default: begin
                        // ack range: gap then length, one pair per count
                        if (!half_ff) begin
                           half_in = 1'b1;
                        end else begin
                           half_in  = 1'b0;
                           pairs_in = pairs_dec;
                           want_adv = (pairs_dec == '0);
                        end
                     end
                  endcase
               end
            end
            OP_U8LEN: begin
               if (b == 8'd0) begin
                  want_adv = 1'b1;
               end else begin
                  skip_cnt_in = 62'(b);
                  skip_in     = 1'b1;
               end
            end
            OP_FIX2: begin
               skip_cnt_in = QFBP_FIX2_SKIP;
               skip_in     = 1'b1;
            end
            OP_FIX8: begin
               skip_cnt_in = QFBP_FIX8_SKIP;
               skip_in     = 1'b1;
            end
            OP_FIX16: begin
               skip_cnt_in = QFBP_FIX16_SKIP;
               skip_in     = 1'b1;
            end
            OP_REST: want_adv = 1'b0;
            default: want_adv = 1'b1;
         endcase
      end

      adv_r = advance_from(kind_ff, step_ff + 4'd1, (pairs_in == '0));
      if (want_adv) begin
         if (adv_r.done) fb_done = 1'b1;
         else step_in = adv_r.step;
      end
      rest_end = !skip_in && (grammar_op(kind_ff, step_in) == OP_REST);

      // top-level dispatch; the frame-byte values above only stand in frame mode
      if (pad_ff) begin
         mode_in     = MODE_TYPE;
         step_in     = step_ff;
         half_in     = half_ff;
         skip_in     = skip_ff;
         acc_in      = acc_ff;
         vleft_in    = vleft_ff;
         skip_cnt_in = skip_cnt_ff;
         pairs_in    = pairs_ff;
         if (b == 8'd0) begin
            count_in = count_inc;
            if (fin) begin
               r0     = make_rsp(QFBP_TYPE_PADDING, sat16(count_inc), STATUS_PAD_END);
               n_res  = 2'd1;
               pad_in = 1'b0;
            end
         end else begin
            // run closes, then this byte opens the next frame
            r0          = make_rsp(QFBP_TYPE_PADDING, sat16(count_ff), STATUS_OK);
            r1          = tb_res;
            n_res       = tb_emit ? 2'd2 : 2'd1;
            pad_in      = tb_pad;
            mode_in     = tb_mode;
            step_in     = adv_type0.step;
            half_in     = 1'b0;
            skip_in     = 1'b0;
            vleft_in    = 3'd0;
            skip_cnt_in = '0;
            pairs_in    = '0;
            kind_in     = b;
            count_in    = COUNT_WIDTH'(1);
         end
      end else begin
         case (mode_ff)
            MODE_DISCARD: begin
               step_in     = step_ff;
               half_in     = half_ff;
               skip_in     = skip_ff;
               acc_in      = acc_ff;
               vleft_in    = vleft_ff;
               skip_cnt_in = skip_cnt_ff;
               pairs_in    = pairs_ff;
               if (fin) mode_in = MODE_TYPE;
            end
            MODE_FRAME: begin
               count_in = count_inc;
               if (fb_done || fin) begin
                  r0          = make_rsp(kind_ff, sat16(count_inc),
                                         (fb_done || rest_end) ? STATUS_OK : STATUS_TRUNC);
                  n_res       = 2'd1;
                  mode_in     = MODE_TYPE;
                  half_in     = 1'b0;
                  skip_in     = 1'b0;
                  vleft_in    = 3'd0;
                  skip_cnt_in = '0;
                  pairs_in    = '0;
               end
            end
            default: begin
               r0          = tb_res;
               n_res       = tb_emit ? 2'd1 : 2'd0;
               pad_in      = tb_pad;
               mode_in     = tb_mode;
               step_in     = adv_type0.step;
               half_in     = 1'b0;
               skip_in     = 1'b0;
               acc_in      = acc_ff;
               vleft_in    = 3'd0;
               skip_cnt_in = '0;
               pairs_in    = '0;
               kind_in     = b;
               count_in    = COUNT_WIDTH'(1);
            end
         endcase
      end

      // flag the last result of this byte
      if (n_res == 2'd1) r0.last_of_run = 1'b1;
      if (n_res == 2'd2) r1.last_of_run = 1'b1;
   end

   always_comb begin
      push.num    = accept ? n_res : 2'd0;
      push.first  = r0;
      push.second = r1;
   end

   // state register, updated once per accepted transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_TYPE;
         step_ff     <= '0;
         half_ff     <= 1'b0;
         skip_ff     <= 1'b0;
         pad_ff      <= 1'b0;
         kind_ff     <= '0;
         vleft_ff    <= '0;
         skip_cnt_ff <= '0;
         pairs_ff    <= '0;
         count_ff    <= '0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         step_ff     <= step_in;
         half_ff     <= half_in;
         skip_ff     <= skip_in;
         pad_ff      <= pad_in;
         kind_ff     <= kind_in;
         vleft_ff    <= vleft_in;
         skip_cnt_ff <= skip_cnt_in;
         pairs_ff    <= pairs_in;
         count_ff    <= count_in;
      end
   end

   // varint accumulator is payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) acc_ff <= acc_in;
   end

   qfbp_rsp_queue u_rsp_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .has_room    (has_room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
